FILE: hw/rtl/scaled_pulse_width_generator_defines.svh
// assertion macros for the scaled pulse width generator
// no dependencies; included by the files that carry assertions
`ifndef SCALED_PULSE_WIDTH_GENERATOR_DEFINES_SVH
`define SCALED_PULSE_WIDTH_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// checked while out of reset
`define SPWG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define SPWG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SPWG_ASSERT(lbl, prop, msg)
`define SPWG_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/spwg_pkg.sv
// shared widths, register indexes, reset values and divider control types
// no dependencies
package spwg_pkg;

    localparam int DUTY_W  = 16;
    localparam int PULSE_W = 32;
    localparam int PROD_W  = PULSE_W + DUTY_W;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_LEN = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE  = 4'd3;

    localparam logic [DUTY_W-1:0]  RESOLUTION_RST = 16'd255;
    localparam logic [PULSE_W-1:0] PERIOD_LEN_RST = 32'd1000;
    localparam logic [PULSE_W-1:0] MIN_PULSE_RST  = 32'd0;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST  = 32'd1000;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

FILE: hw/rtl/spwg_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on spwg_pkg; quotient is known to fit PULSE_W bits
`include "scaled_pulse_width_generator_defines.svh"

module spwg_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  spwg_pkg::t_div_ctl               i_ctl,
    input  logic [spwg_pkg::PROD_W-1:0]      i_dividend,
    input  logic [spwg_pkg::DUTY_W-1:0]      i_divisor,
    output spwg_pkg::t_div_sts               o_sts,
    output logic [spwg_pkg::PULSE_W-1:0]     o_quotient
);

    localparam int CNT_W = $clog2(spwg_pkg::PULSE_W);

    logic                          r_busy;
    logic [CNT_W-1:0]              r_cnt;
    logic [spwg_pkg::DUTY_W-1:0]   r_rem;
    logic [spwg_pkg::PULSE_W-1:0]  r_low;
    logic [spwg_pkg::DUTY_W-1:0]   r_div;

    logic [spwg_pkg::DUTY_W:0]     trial;
    logic [spwg_pkg::DUTY_W:0]     diff;
    logic                          qbit;
    logic                          last;

    assign trial = {r_rem, r_low[spwg_pkg::PULSE_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign qbit  = (trial >= {1'b0, r_div});
    assign last  = (r_cnt == CNT_W'(spwg_pkg::PULSE_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            // upper half is already below any nonzero divisor
            r_rem  <= i_dividend[spwg_pkg::PROD_W-1:spwg_pkg::PULSE_W];
            r_low  <= i_dividend[spwg_pkg::PULSE_W-1:0];
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[spwg_pkg::DUTY_W-1:0] : trial[spwg_pkg::DUTY_W-1:0];
            r_low <= {r_low[spwg_pkg::PULSE_W-2:0], qbit};
            if (last) begin
                r_busy <= 1'b0;
                r_cnt  <= '0;
            end else begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_busy && last;
    assign o_quotient = r_low;

    `SPWG_ASSERT(a_no_restart, i_ctl.start |-> !r_busy, "divider started while busy")
    `SPWG_ASSERT(a_done_ends, o_sts.done |=> !r_busy, "divider still busy after done")
    `SPWG_ASSERT(a_cnt_idle, !r_busy |-> (r_cnt == '0), "divider count nonzero while idle")

endmodule

FILE: hw/rtl/scaled_pulse_width_generator.sv
// top level of the scaled pulse width generator: sequencer, state and config
// depends on spwg_pkg and spwg_div
`include "scaled_pulse_width_generator_defines.svh"

// Each poll word (time, duty request) updates a two-phase pulse output whose busy
// time runs from min_pulse at duty 0 to max_pulse at full-scale duty, scaled
// exactly as floor(span * duty / resolution). A poll passes from acceptance to
// its result word through the 32x16 multiply, the divider load, the bit-serial
// divide by resolution, and the busy time, idle time and phase/deadline update,
// which waits while the previous result word is still stalled. The input side
// stalls while a poll is in work and takes the next one in the cycle after the
// result is written to the output register, even if that word is still waiting.
// Configuration writes are always accepted and must only be made while idle.
module scaled_pulse_width_generator #(
    parameter int TIME_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [spwg_pkg::PULSE_W-1:0]       i_now_time,
    input  logic [spwg_pkg::DUTY_W-1:0]        i_duty_request,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_pin_level,
    output logic                               o_phase,
    output logic                               o_clamped,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [spwg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [spwg_pkg::PULSE_W-1:0]       i_cfg_data
);

    localparam int NOW_W = (TIME_BITS < spwg_pkg::PULSE_W) ? TIME_BITS : spwg_pkg::PULSE_W;
    localparam int SUM_W = (TIME_BITS > spwg_pkg::PULSE_W) ? TIME_BITS : spwg_pkg::PULSE_W;

    typedef enum logic [2:0] {
        S_WAIT, S_MUL, S_START, S_DIV, S_BUSY, S_IDLE_T, S_UPD
    } t_state;

    t_state                         r_state;

    logic [spwg_pkg::DUTY_W-1:0]    r_resolution;
    logic [spwg_pkg::PULSE_W-1:0]   r_period_len;
    logic [spwg_pkg::PULSE_W-1:0]   r_min_pulse;
    logic [spwg_pkg::PULSE_W-1:0]   r_max_pulse;

    logic [TIME_BITS-1:0]           r_deadline;
    logic                           r_phase;
    logic                           r_pin;
    logic                           r_out_valid;
    logic                           r_out_sat;

    logic [TIME_BITS-1:0]           r_now;
    logic [spwg_pkg::DUTY_W-1:0]    r_duty;
    logic [spwg_pkg::PULSE_W-1:0]   r_span;
    logic                           r_sat;
    logic [spwg_pkg::PROD_W-1:0]    r_prod;
    logic [spwg_pkg::PULSE_W-1:0]   r_busy_t;
    logic [spwg_pkg::PULSE_W-1:0]   r_idle_t;

    spwg_pkg::t_div_ctl             div_ctl;
    spwg_pkg::t_div_sts             div_sts;
    logic [spwg_pkg::PULSE_W-1:0]   quotient;

    logic                           in_take;
    logic                           out_free;
    logic [spwg_pkg::PULSE_W-1:0]   scale;
    logic [spwg_pkg::PULSE_W-1:0]   phase_t;
    logic [SUM_W-1:0]               dl_sum;

    assign in_take  = i_in_valid && (r_state == S_WAIT);
    assign out_free = !r_out_valid || !i_out_stall;
    assign scale    = (r_resolution == '0) ? '0 : quotient;
    assign phase_t  = r_phase ? r_idle_t : r_busy_t;
    assign dl_sum   = SUM_W'(r_now) + SUM_W'(phase_t);

    assign div_ctl.start = (r_state == S_START);

    spwg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (r_prod),
        .i_divisor  (r_resolution),
        .o_sts      (div_sts),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_WAIT;
            r_resolution <= spwg_pkg::RESOLUTION_RST;
            r_period_len <= spwg_pkg::PERIOD_LEN_RST;
            r_min_pulse  <= spwg_pkg::MIN_PULSE_RST;
            r_max_pulse  <= spwg_pkg::MAX_PULSE_RST;
            r_deadline   <= '0;
            r_phase      <= 1'b0;
            r_pin        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_sat    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    spwg_pkg::CFG_RESOLUTION: r_resolution <= i_cfg_data[spwg_pkg::DUTY_W-1:0];
                    spwg_pkg::CFG_PERIOD_LEN: r_period_len <= i_cfg_data;
                    spwg_pkg::CFG_MIN_PULSE:  r_min_pulse  <= i_cfg_data;
                    spwg_pkg::CFG_MAX_PULSE:  r_max_pulse  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_WAIT: begin
                    if (in_take) begin
                        r_now <= TIME_BITS'(i_now_time[NOW_W-1:0]);
                        if (i_duty_request > r_resolution) begin
                            r_duty <= r_resolution;
                        end else begin
                            r_duty <= i_duty_request;
                        end
                        if (r_max_pulse >= r_min_pulse) begin
                            r_span <= r_max_pulse - r_min_pulse;
                        end else begin
                            r_span <= '0;
                        end
                        r_sat   <= (i_duty_request > r_resolution) ||
                                   (r_max_pulse < r_min_pulse);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= spwg_pkg::PROD_W'(r_span) * spwg_pkg::PROD_W'(r_duty);
                    r_state <= S_START;
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_sts.done) begin
                        r_state <= S_BUSY;
                    end
                end
                S_BUSY: begin
                    // cannot overflow: scale never exceeds the span
                    r_busy_t <= r_min_pulse + scale;
                    r_state  <= S_IDLE_T;
                end
                S_IDLE_T: begin
                    if (r_busy_t <= r_period_len) begin
                        r_idle_t <= r_period_len - r_busy_t;
                    end else begin
                        r_idle_t <= '0;
                        r_sat    <= 1'b1;
                    end
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (out_free) begin
                        if (r_now > r_deadline) begin
                            r_deadline <= dl_sum[TIME_BITS-1:0];
                            r_phase    <= !r_phase;
                            // zero-length phase leaves the pin where it is
                            if (phase_t != '0) begin
                                r_pin <= !r_phase;
                            end
                        end
                        r_out_sat   <= r_sat;
                        r_out_valid <= 1'b1;
                        r_state     <= S_WAIT;
                    end
                end
                default: r_state <= S_WAIT;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_WAIT);
    assign o_out_valid = r_out_valid;
    assign o_pin_level = r_pin;
    assign o_phase     = r_phase;
    assign o_clamped   = r_out_sat;
    assign o_cfg_ready = 1'b1;

    `SPWG_ASSERT(a_done_in_div, div_sts.done |-> (r_state == S_DIV), "divider done outside divide")
    `SPWG_ASSERT(a_word_from_upd, $rose(o_out_valid) |-> $past(r_state == S_UPD), "result word without update")
    `SPWG_ASSERT(a_phase_with_word, !$stable(r_phase) |-> o_out_valid, "phase moved without a result word")
    `SPWG_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> (!o_out_valid && !o_in_stall), "not quiet after reset")

endmodule

FILE: dv/scaled_pulse_width_generator_tb.sv
// self-checking testbench for scaled_pulse_width_generator: directed corners, then random polls
// depends on spwg_pkg and the block's rtl; holds its own pulse predictor and word scoreboard
`timescale 1ns / 100ps

module scaled_pulse_width_generator_tb;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TOTAL_POLLS    = 1500;
    localparam int QUIET_FROM     = 1275;
    localparam int TAIL_CYCLES    = 60;
    localparam logic [spwg_pkg::CFG_IDX_W-1:0] CFG_FIRST_UNUSED =
        spwg_pkg::CFG_MAX_PULSE + 1'b1;
    localparam logic [spwg_pkg::CFG_IDX_W-1:0] CFG_LAST_UNUSED  = '1;

    typedef struct packed {
        logic pin_level;
        logic phase;
        logic clamped;
    } t_pwm_word;

    // predicts pin/phase/clamp per poll and keeps the words still owed by the block
    class t_pulse_tracker;
        logic [spwg_pkg::DUTY_W-1:0]  full_scale;
        logic [spwg_pkg::PULSE_W-1:0] period;
        logic [spwg_pkg::PULSE_W-1:0] busy_floor;
        logic [spwg_pkg::PULSE_W-1:0] busy_ceil;
        logic [spwg_pkg::PULSE_W-1:0] next_edge;
        logic                         phase_q;
        logic                         pin_q;
        t_pwm_word                    expected_levels[$];
        int                           mismatches;
        int                           words_checked;

        function new();
            full_scale    = spwg_pkg::RESOLUTION_RST;
            period        = spwg_pkg::PERIOD_LEN_RST;
            busy_floor    = spwg_pkg::MIN_PULSE_RST;
            busy_ceil     = spwg_pkg::MAX_PULSE_RST;
            next_edge     = '0;
            phase_q       = 1'b0;
            pin_q         = 1'b0;
            mismatches    = 0;
            words_checked = 0;
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction

        function void write_reg(logic [spwg_pkg::CFG_IDX_W-1:0] idx,
                                logic [spwg_pkg::PULSE_W-1:0] data);
            case (idx)
                spwg_pkg::CFG_RESOLUTION: full_scale = data[spwg_pkg::DUTY_W-1:0];
                spwg_pkg::CFG_PERIOD_LEN: period     = data;
                spwg_pkg::CFG_MIN_PULSE:  busy_floor = data;
                spwg_pkg::CFG_MAX_PULSE:  busy_ceil  = data;
                default: ;
            endcase
        endfunction

        function void note_poll(logic [spwg_pkg::PULSE_W-1:0] now,
                                logic [spwg_pkg::DUTY_W-1:0] req);
            logic [spwg_pkg::DUTY_W-1:0]  duty;
            logic [spwg_pkg::PULSE_W-1:0] span;
            logic [spwg_pkg::PULSE_W-1:0] busy;
            logic [spwg_pkg::PULSE_W-1:0] idle;
            logic [spwg_pkg::PROD_W-1:0]  span_w;
            logic [spwg_pkg::PROD_W-1:0]  duty_w;
            logic [spwg_pkg::PROD_W-1:0]  scaled;
            logic                         sat;
            t_pwm_word                    w;
            sat  = 1'b0;
            duty = req;
            if (req > full_scale) begin
                duty = full_scale;
                sat  = 1'b1;
            end
            if (busy_ceil >= busy_floor) begin
                span = busy_ceil - busy_floor;
            end else begin
                span = '0;
                sat  = 1'b1;
            end
            span_w = spwg_pkg::PROD_W'(span);
            duty_w = spwg_pkg::PROD_W'(duty);
            // duty never exceeds full_scale, so scaled fits in the span width
            scaled = (full_scale != 0) ? (span_w * duty_w) / full_scale : '0;
            busy   = busy_floor + scaled[spwg_pkg::PULSE_W-1:0];
            if (busy <= period) begin
                idle = period - busy;
            end else begin
                idle = '0;
                sat  = 1'b1;
            end
            if (now > next_edge) begin
                if (phase_q) begin
                    next_edge = now + idle;
                    if (idle != 0) pin_q = 1'b0;
                    phase_q = 1'b0;
                end else begin
                    next_edge = now + busy;
                    if (busy != 0) pin_q = 1'b1;
                    phase_q = 1'b1;
                end
            end
            w.pin_level = pin_q;
            w.phase     = phase_q;
            w.clamped   = sat;
            expected_levels.push_back(w);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("tb: mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_word(t_pwm_word got);
            t_pwm_word want;
            if (expected_levels.size() == 0) begin
                report_mismatch($sformatf("word %0d arrived with nothing owed", words_checked));
            end else begin
                want = expected_levels.pop_front();
                if (got.pin_level !== want.pin_level)
                    report_mismatch($sformatf("word %0d pin_level %b, want %b",
                                              words_checked, got.pin_level, want.pin_level));
                if (got.phase !== want.phase)
                    report_mismatch($sformatf("word %0d phase %b, want %b",
                                              words_checked, got.phase, want.phase));
                if (got.clamped !== want.clamped)
                    report_mismatch($sformatf("word %0d clamped %b, want %b",
                                              words_checked, got.clamped, want.clamped));
            end
            words_checked++;
        endtask
    endclass

    logic                           i_clk          = 1'b0;
    logic                           i_rst_n        = 1'b0;
    logic                           i_in_valid     = 1'b0;
    logic                           o_in_stall;
    logic [spwg_pkg::PULSE_W-1:0]   i_now_time     = '0;
    logic [spwg_pkg::DUTY_W-1:0]    i_duty_request = '0;
    logic                           o_out_valid;
    logic                           i_out_stall    = 1'b0;
    logic                           o_pin_level;
    logic                           o_phase;
    logic                           o_clamped;
    logic                           i_cfg_valid    = 1'b0;
    logic                           o_cfg_ready;
    logic [spwg_pkg::CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [spwg_pkg::PULSE_W-1:0]   i_cfg_data     = '0;

    t_pulse_tracker                 tracker = new();
    t_pwm_word                      seen_word;
    logic [spwg_pkg::PULSE_W-1:0]   last_now      = '0;
    bit                             quiet_tail    = 1'b0;
    int                             gap_pct       = 30;
    int                             polls_sent    = 0;
    int                             writes_done   = 0;
    int                             setting_count = 0;
    int                             quiet_cycles  = 0;
    int                             stall_left    = 0;

    always #10 i_clk = ~i_clk;

    scaled_pulse_width_generator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_now_time     (i_now_time),
        .i_duty_request (i_duty_request),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pin_level    (o_pin_level),
        .o_phase        (o_phase),
        .o_clamped      (o_clamped),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // result side: check words, track progress for the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                seen_word.pin_level = o_pin_level;
                seen_word.phase     = o_phase;
                seen_word.clamped   = o_clamped;
                tracker.check_word(seen_word);
            end
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // receiver back-pressure in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet_tail) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 15) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 8);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("tb: no handshake for %0d cycles, %0d words still owed",
                 WATCHDOG_LIMIT, tracker.pending());
        $display("tb: failure");
        $finish;
    end

    // called from the clocked sequence; valid is left high for a following word
    task send_poll(logic [spwg_pkg::PULSE_W-1:0] now, logic [spwg_pkg::DUTY_W-1:0] duty);
        i_in_valid     <= 1'b1;
        i_now_time     <= now;
        i_duty_request <= duty;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_poll(now, duty);
        last_now = now;
        polls_sent++;
    endtask

    task idle_gap();
        if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task cfg_word(logic [spwg_pkg::CFG_IDX_W-1:0] idx, logic [spwg_pkg::PULSE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, data);
        writes_done++;
    endtask

    task program_settings(logic [spwg_pkg::PULSE_W-1:0] res, logic [spwg_pkg::PULSE_W-1:0] per,
                          logic [spwg_pkg::PULSE_W-1:0] lo, logic [spwg_pkg::PULSE_W-1:0] hi,
                          bit junk);
        int unsigned junk_idx;
        cfg_word(spwg_pkg::CFG_RESOLUTION, res);
        cfg_word(spwg_pkg::CFG_PERIOD_LEN, per);
        cfg_word(spwg_pkg::CFG_MIN_PULSE, lo);
        cfg_word(spwg_pkg::CFG_MAX_PULSE, hi);
        // unmapped index must leave every register alone
        if (junk) begin
            junk_idx = $urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED);
            cfg_word(junk_idx[spwg_pkg::CFG_IDX_W-1:0], $urandom);
        end
        i_cfg_valid <= 1'b0;
        setting_count++;
    endtask

    // drop valid and wait for every owed word before touching registers
    task settle();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [spwg_pkg::PULSE_W-1:0] pick_now();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return tracker.next_edge + $urandom_range(0, 2);
        else if (r < 75) return last_now + $urandom_range(0, 2 * tracker.period[11:0] + 2);
        else if (r < 83) return last_now;
        else if (r < 93) return $urandom;
        else return '1 - $urandom_range(0, 3);
    endfunction

    function automatic logic [spwg_pkg::DUTY_W-1:0] pick_duty();
        int unsigned                  r;
        logic [spwg_pkg::PULSE_W-1:0] v;
        logic [spwg_pkg::PULSE_W-1:0] fs;
        r  = $urandom_range(0, 99);
        fs = spwg_pkg::PULSE_W'(tracker.full_scale);
        if (r < 55) v = $urandom_range(0, tracker.full_scale);
        else if (r < 65) v = fs;
        else if (r < 72) v = '0;
        else if (r < 82) v = (tracker.full_scale == '1) ? fs : fs + 1'b1;
        else if (r < 94) v = $urandom;
        else v = '1;
        return v[spwg_pkg::DUTY_W-1:0];
    endfunction

    function automatic logic [spwg_pkg::PULSE_W-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'd1;
            2: return '1;
            3: return 32'hFFFF_FFFE;
            4: return $urandom_range(0, 16);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned                  kind;
        int                           n;
        logic [spwg_pkg::PULSE_W-1:0] res;
        logic [spwg_pkg::PULSE_W-1:0] per;
        logic [spwg_pkg::PULSE_W-1:0] lo;
        logic [spwg_pkg::PULSE_W-1:0] hi;
        logic [spwg_pkg::PULSE_W-1:0] tmp;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: equal-time no-toggle, zero busy and idle keep the pin, wrap
        send_poll(32'd0, 16'd0);
        send_poll(32'd1, 16'd0);
        send_poll(32'd1, 16'd255);
        send_poll(32'd2, 16'd255);
        send_poll(32'd3, 16'd300);
        send_poll(32'd1003, 16'hFFFF);
        send_poll(32'd1004, 16'd128);
        send_poll(32'hFFFF_FFF0, 16'd100);
        send_poll(32'hFFFF_FFFF, 16'd0);
        send_poll(32'd5, 16'd255);

        // zero resolution, inverted span, busy past a zero period
        settle();
        program_settings(32'd0, 32'd0, 32'd7, 32'd3, 1'b1);
        send_poll(tracker.next_edge + 1, 16'd0);
        send_poll(tracker.next_edge + 1, 16'd5);
        send_poll(tracker.next_edge, 16'hFFFF);
        send_poll(tracker.next_edge + 2, 16'd1);

        // widest span and period
        settle();
        program_settings(32'h0000_FFFF, '1, 32'd0, '1, 1'b1);
        send_poll(tracker.next_edge + 1, 16'hFFFF);
        send_poll(tracker.next_edge + 1, 16'd0);
        send_poll(tracker.next_edge + 1, 16'h8000);
        send_poll(tracker.next_edge + 1, 16'd1);
        send_poll(32'hFFFF_FFFF, 16'hFFFF);

        while (polls_sent < TOTAL_POLLS) begin
            settle();
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                res = ($urandom_range(0, 7) == 0) ? 32'h0000_FFFF : $urandom_range(1, 1023);
                per = $urandom_range(1, 3000);
                lo  = $urandom_range(0, per / 2);
                hi  = $urandom_range(lo, per);
                if ($urandom_range(0, 9) == 0) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
            end else if (kind < 9) begin
                res = pick_extreme();
                per = pick_extreme();
                lo  = pick_extreme();
                hi  = pick_extreme();
            end else begin
                res = $urandom;
                per = $urandom;
                lo  = $urandom;
                hi  = $urandom;
            end
            program_settings(res, per, lo, hi, ($urandom_range(0, 1) == 1));
            gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
            n = $urandom_range(60, 140);
            for (int i = 0; i < n && polls_sent < TOTAL_POLLS; i++) begin
                quiet_tail = (polls_sent >= QUIET_FROM);
                idle_gap();
                send_poll(pick_now(), pick_duty());
            end
        end

        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("tb: %0d polls over %0d register settings, %0d words checked",
                 polls_sent, setting_count, tracker.words_checked);
        $display("tb: %0d register writes, %0d mismatches", writes_done, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: scaled_pulse_width_generator.f
+incdir+hw/rtl
hw/rtl/spwg_pkg.sv
hw/rtl/spwg_div.sv
hw/rtl/scaled_pulse_width_generator.sv
dv/scaled_pulse_width_generator_tb.sv
